### sv/mbet_pkg.sv
package mbet_pkg;

  // Field widths of the ports.
  localparam int unsigned DIM_CFG_W   = 13;
  localparam int unsigned POWER_CFG_W = 4;
  localparam int unsigned ITER_CFG_W  = 11;
  localparam int unsigned PIXEL_W     = 12;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_POWER          = 2'd2,
    CFG_MAX_ITERATIONS = 2'd3
  } cfg_idx_t;

  // Identifies which scale a request in the divider row belongs to.
  typedef enum logic {
    DIV_TAG_X = 1'b0,
    DIV_TAG_Y = 1'b1
  } div_tag_t;

endpackage

### sv/mbet_div_cell.sv
module mbet_div_cell #(
  parameter int unsigned DW = 13,
  parameter int unsigned NW = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_in,
  input  mbet_pkg::div_tag_t     tag_in,
  input  logic [DW-1:0]          div_in,
  input  logic [DW-1:0]          rem_in,
  input  logic [NW-1:0]          num_in,
  input  logic [NW-1:0]          quo_in,
  output logic                   valid_out,
  output mbet_pkg::div_tag_t     tag_out,
  output logic [DW-1:0]          div_out,
  output logic [DW-1:0]          rem_out,
  output logic [NW-1:0]          num_out,
  output logic [NW-1:0]          quo_out
);
  import mbet_pkg::*;

  logic [DW:0]   trial;
  logic          fits;
  logic [DW:0]   diff;
  logic          valid_r;
  div_tag_t      tag_r;
  logic [DW-1:0] div_r;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] num_r;
  logic [NW-1:0] quo_r;

  // One restoring step: bring down the next numerator bit and try to subtract.
  assign trial = {rem_in, num_in[NW-1]};
  assign fits  = (trial >= {1'b0, div_in});
  assign diff  = trial - {1'b0, div_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  // Payload moves on to the next cell every cycle.
  always_ff @(posedge clk) begin
    tag_r <= tag_in;
    div_r <= div_in;
    rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
    num_r <= {num_in[NW-2:0], 1'b0};
    quo_r <= {quo_in[NW-2:0], fits};
  end

  assign valid_out = valid_r;
  assign tag_out   = tag_r;
  assign div_out   = div_r;
  assign rem_out   = rem_r;
  assign num_out   = num_r;
  assign quo_out   = quo_r;

endmodule

### sv/multibrot_escape_time_unit.sv
// Multibrot escape-time evaluator for one pixel per request.
// Input channel in_*: a pixel column and row; in_stall is high while a pixel is
// being evaluated, so one pixel is in work at a time.
// Output channel out_*: the iteration count; it is held in an output register
// until the receiver drops out_stall, and a new pixel may be taken meanwhile.
// The pixel scales 3/width and 3/height come from a row of restoring divider
// cells, one quotient bit per cell. Each escape iteration then steps through
// the squares of |z|, the compare, up to power-1 complex multiplies (four real
// products, then rounding) and the addition of c.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the
// user is to write it only while the unit is idle, which the unit itself does
// not enforce. Reset restores width 640, height 480, power 2 and a limit
// of 256, and empties both channels.
module multibrot_escape_time_unit #(
  parameter int unsigned MAX_DIM    = 4096,
  parameter int unsigned ITER_LIMIT = 1024,
  parameter int unsigned FRAC_BITS  = 28,
  parameter int unsigned MAX_POWER  = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mbet_pkg::PIXEL_W-1:0]         in_pixel_col,
  input  logic [mbet_pkg::PIXEL_W-1:0]         in_pixel_row,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mbet_pkg::ITER_CFG_W-1:0]      out_iteration_count,
  input  logic                                 cfg_wr_en,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbet_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import mbet_pkg::*;

  localparam int unsigned W    = FRAC_BITS + 4;
  localparam int unsigned DW   = $clog2(MAX_DIM + 1);
  localparam int unsigned NW   = FRAC_BITS + 3;
  localparam int unsigned PXW  = (DW > PIXEL_W) ? DW : PIXEL_W;
  localparam int unsigned OW   = PXW + 2;
  localparam int unsigned CPW  = OW + NW + 1;
  localparam int unsigned PW   = $clog2(MAX_POWER + 1);
  localparam int unsigned CW   = $clog2(ITER_LIMIT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVW, S_DIVH, S_DWAIT, S_CR, S_CI,
    S_MAG, S_CMP, S_MUL, S_RND, S_ADD, S_FIN
  } state_t;

  // Configuration registers.
  logic [DIM_CFG_W-1:0]   width_r, height_r;
  logic [POWER_CFG_W-1:0] power_r;
  logic [ITER_CFG_W-1:0]  max_iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= DIM_CFG_W'(640);
      height_r   <= DIM_CFG_W'(480);
      power_r    <= POWER_CFG_W'(2);
      max_iter_r <= ITER_CFG_W'(256);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:    width_r    <= cfg_wdata[DIM_CFG_W-1:0];
        CFG_IMAGE_HEIGHT:   height_r   <= cfg_wdata[DIM_CFG_W-1:0];
        CFG_POWER:          power_r    <= cfg_wdata[POWER_CFG_W-1:0];
        CFG_MAX_ITERATIONS: max_iter_r <= cfg_wdata[ITER_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped settings.
  logic [31:0]   w32, h32, p32, l32;
  logic [DW-1:0] dim_w, dim_h;
  logic [PW-1:0] pow_eff;
  logic [CW-1:0] lim_eff;

  assign w32 = 32'(width_r);
  assign h32 = 32'(height_r);
  assign p32 = 32'(power_r);
  assign l32 = 32'(max_iter_r);
  assign dim_w = (w32 == 32'd0) ? DW'(1) : ((w32 > MAX_DIM) ? DW'(MAX_DIM) : DW'(w32));
  assign dim_h = (h32 == 32'd0) ? DW'(1) : ((h32 > MAX_DIM) ? DW'(MAX_DIM) : DW'(h32));
  assign pow_eff = (p32 == 32'd0) ? PW'(1) :
                   ((p32 > MAX_POWER) ? PW'(MAX_POWER) : PW'(p32));
  assign lim_eff = (l32 > ITER_LIMIT) ? CW'(ITER_LIMIT) : CW'(l32);

  // Divider row feeding the scales.
  logic                 dv  [NW+1];
  div_tag_t             dt  [NW+1];
  logic [DW-1:0]        dd  [NW+1];
  logic [DW-1:0]        dr  [NW+1];
  logic [NW-1:0]        dn  [NW+1];
  logic [NW-1:0]        dq  [NW+1];
  logic [DW-1:0]        inj_dim;
  state_t               state_r;

  assign inj_dim = (state_r == S_DIVH) ? dim_h : dim_w;
  assign dv[0] = (state_r == S_DIVW) || (state_r == S_DIVH);
  assign dt[0] = (state_r == S_DIVH) ? DIV_TAG_Y : DIV_TAG_X;
  assign dd[0] = inj_dim;
  assign dr[0] = '0;
  assign dn[0] = (NW'(3) << FRAC_BITS) + NW'(inj_dim >> 1);
  assign dq[0] = '0;

  for (genvar g = 0; g < NW; g++) begin : g_div
    mbet_div_cell #(.DW(DW), .NW(NW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (dv[g]),
      .tag_in    (dt[g]),
      .div_in    (dd[g]),
      .rem_in    (dr[g]),
      .num_in    (dn[g]),
      .quo_in    (dq[g]),
      .valid_out (dv[g+1]),
      .tag_out   (dt[g+1]),
      .div_out   (dd[g+1]),
      .rem_out   (dr[g+1]),
      .num_out   (dn[g+1]),
      .quo_out   (dq[g+1])
    );
  end

  // Datapath registers.
  logic [PIXEL_W-1:0]     col_r, row_r;
  logic [NW-1:0]          sx_r, sy_r;
  logic signed [W-1:0]    cr_r, ci_r, zr_r, zi_r, ar_r, ai_r;
  logic signed [2*W-1:0]  sqr_r, sqi_r, p1_r, p2_r, p3_r, p4_r;
  logic [PW-1:0]          k_r;
  logic [CW-1:0]          cnt_r;
  logic                   out_valid_r;
  logic [ITER_CFG_W-1:0]  out_cnt_r;

  // Pixel coordinate: (pos - dim/2) * scale, saturated.
  logic signed [OW-1:0]   off;
  logic signed [CPW-1:0]  cprod;
  logic signed [W-1:0]    csat;
  logic signed [CPW-1:0]  cposx, cnegx;
  logic [PXW-1:0]         cpos;
  logic [DW-1:0]          chalf;
  logic [NW-1:0]          cscale;

  assign cpos   = (state_r == S_CI) ? PXW'(row_r) : PXW'(col_r);
  assign chalf  = ((state_r == S_CI) ? dim_h : dim_w) >> 1;
  assign cscale = (state_r == S_CI) ? sy_r : sx_r;
  assign off    = $signed({2'b00, cpos}) - $signed({2'b00, PXW'(chalf)});
  assign cprod  = CPW'(off) * CPW'($signed({1'b0, cscale}));
  assign cposx  = {{(CPW-W+1){1'b0}}, {(W-1){1'b1}}};
  assign cnegx  = {{(CPW-W+1){1'b1}}, {(W-1){1'b0}}};
  assign csat   = (cprod > cposx) ? W'(cposx) : ((cprod < cnegx) ? W'(cnegx) : W'(cprod));

  // Rounding of the complex product components.
  logic signed [2*W:0] posx, negx, half, sum_re, sum_im, sh_re, sh_im;
  logic signed [W-1:0] nr, ni;
  logic                ovf_re, ovf_im;

  assign posx   = {{(W+2){1'b0}}, {(W-1){1'b1}}};
  assign negx   = {{(W+2){1'b1}}, {(W-1){1'b0}}};
  assign half   = (2*W+1)'(1) <<< (FRAC_BITS - 1);
  assign sum_re = (2*W+1)'(p1_r) - (2*W+1)'(p2_r) + half;
  assign sum_im = (2*W+1)'(p3_r) + (2*W+1)'(p4_r) + half;
  assign sh_re  = sum_re >>> FRAC_BITS;
  assign sh_im  = sum_im >>> FRAC_BITS;
  assign ovf_re = (sh_re > posx) || (sh_re < negx);
  assign ovf_im = (sh_im > posx) || (sh_im < negx);
  assign nr = (sh_re > posx) ? W'(posx) : ((sh_re < negx) ? W'(negx) : W'(sh_re));
  assign ni = (sh_im > posx) ? W'(posx) : ((sh_im < negx) ? W'(negx) : W'(sh_im));

  // Adding c with saturation.
  logic signed [W:0]   ad_re, ad_im, aposx, anegx;
  logic signed [W-1:0] zr_nxt, zi_nxt;
  logic                ovf_add;
  logic                ovf_r;

  assign aposx  = {2'b00, {(W-1){1'b1}}};
  assign anegx  = {2'b11, {(W-1){1'b0}}};
  assign ad_re  = (W+1)'(ar_r) + (W+1)'(cr_r);
  assign ad_im  = (W+1)'(ai_r) + (W+1)'(ci_r);
  assign zr_nxt = (ad_re > aposx) ? W'(aposx) : ((ad_re < anegx) ? W'(anegx) : W'(ad_re));
  assign zi_nxt = (ad_im > aposx) ? W'(aposx) : ((ad_im < anegx) ? W'(anegx) : W'(ad_im));
  assign ovf_add = (ad_re > aposx) || (ad_re < anegx) || (ad_im > aposx) || (ad_im < anegx);

  // Escape test against four.
  logic [2*W:0] mag, four;
  logic [CW-1:0] cnt_inc;
  logic [PW:0]   k_inc;

  assign mag     = {1'b0, sqr_r} + {1'b0, sqi_r};
  assign four    = (2*W+1)'(1) << (2*FRAC_BITS + 2);
  assign cnt_inc = cnt_r + CW'(1);
  assign k_inc   = {1'b0, k_r} + (PW+1)'(1);

  // The output register takes a new count when it is empty or being emptied.
  logic out_load;

  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  // Sequencer with registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            col_r   <= in_pixel_col;
            row_r   <= in_pixel_row;
            state_r <= S_DIVW;
          end
        end
        S_DIVW:  state_r <= S_DIVH;
        S_DIVH:  state_r <= S_DWAIT;
        S_DWAIT: begin
          if (dv[NW]) begin
            if (dt[NW] == DIV_TAG_Y) begin
              sy_r    <= dq[NW];
              state_r <= S_CR;
            end else begin
              sx_r <= dq[NW];
            end
          end
        end
        S_CR: begin
          cr_r    <= csat;
          state_r <= S_CI;
        end
        S_CI: begin
          ci_r    <= csat;
          zr_r    <= '0;
          zi_r    <= '0;
          cnt_r   <= '0;
          state_r <= (lim_eff == '0) ? S_FIN : S_MAG;
        end
        S_MAG: begin
          sqr_r   <= zr_r * zr_r;
          sqi_r   <= zi_r * zi_r;
          state_r <= S_CMP;
        end
        S_CMP: begin
          ar_r  <= zr_r;
          ai_r  <= zi_r;
          k_r   <= PW'(1);
          ovf_r <= 1'b0;
          if (mag >= four) begin
            state_r <= S_FIN;
          end else if (pow_eff > PW'(1)) begin
            state_r <= S_MUL;
          end else begin
            state_r <= S_ADD;
          end
        end
        S_MUL: begin
          p1_r    <= ar_r * zr_r;
          p2_r    <= ai_r * zi_r;
          p3_r    <= ar_r * zi_r;
          p4_r    <= ai_r * zr_r;
          state_r <= S_RND;
        end
        S_RND: begin
          ar_r  <= nr;
          ai_r  <= ni;
          ovf_r <= ovf_re || ovf_im;
          k_r   <= k_inc[PW-1:0];
          if ((k_inc < {1'b0, pow_eff}) && !(ovf_re || ovf_im)) begin
            state_r <= S_MUL;
          end else begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          zr_r  <= zr_nxt;
          zi_r  <= zi_nxt;
          cnt_r <= cnt_inc;
          if (ovf_r || ovf_add || (cnt_inc >= lim_eff)) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_MAG;
          end
        end
        S_FIN: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_cnt_r   <= ITER_CFG_W'(cnt_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_cnt_r;

endmodule

### tb/multibrot_escape_time_unit_tb.sv
module multibrot_escape_time_unit_tb;
  import mbet_pkg::*;

  localparam int unsigned FRAC = 28;
  localparam longint CYCLE_LIMIT = 20000000;

  // Tracks the outstanding iteration counts and mirrors the register file.
  class escape_count_board;
    int unsigned width_reg = 640;
    int unsigned height_reg = 480;
    int unsigned power_reg = 2;
    int unsigned limit_reg = 256;
    bit [ITER_CFG_W-1:0] count_q[$];
    int mismatches = 0;

    function void write_reg(cfg_idx_t idx, int unsigned val);
      case (idx)
        CFG_IMAGE_WIDTH: width_reg = val & 13'h1fff;
        CFG_IMAGE_HEIGHT: height_reg = val & 13'h1fff;
        CFG_POWER: power_reg = val & 4'hf;
        CFG_MAX_ITERATIONS: limit_reg = val & 11'h7ff;
        default: ;
      endcase
    endfunction

    // Saturates a wide value into the Q4 range, flagging any clipping.
    function automatic longint clip_q4(logic signed [127:0] v, inout bit ovf);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = (128'sd1 <<< 31) - 1;
      lo_lim = -(128'sd1 <<< 31);
      if (v > hi_lim) begin
        ovf = 1'b1;
        return longint'(hi_lim);
      end
      if (v < lo_lim) begin
        ovf = 1'b1;
        return longint'(lo_lim);
      end
      return longint'(v);
    endfunction

    function automatic longint point_coord(longint pos, int unsigned dim);
      longint d;
      longint scale;
      logic signed [127:0] prod;
      bit unused_ovf;
      d = (dim == 0) ? 1 : (dim > 4096 ? 4096 : dim);
      scale = ((longint'(3) <<< FRAC) + d / 2) / d;
      prod = 128'(pos - d / 2) * 128'(scale);
      unused_ovf = 1'b0;
      return clip_q4(prod, unused_ovf);
    endfunction

    // One rounded component of a complex product: p*q +/- r*s.
    function automatic longint round_sum(logic signed [127:0] t, inout bit ovf);
      t = (t + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
      return clip_q4(t, ovf);
    endfunction

    function automatic bit [ITER_CFG_W-1:0] escape_count(longint col, longint row);
      longint cr, ci, zr, zi, ar, ai, nr, ni;
      int unsigned pw, lim, cnt;
      logic signed [127:0] mag2;
      bit ovf;
      cr = point_coord(col, width_reg);
      ci = point_coord(row, height_reg);
      pw = (power_reg == 0) ? 1 : (power_reg > 8 ? 8 : power_reg);
      lim = (limit_reg > 1024) ? 1024 : limit_reg;
      zr = 0;
      zi = 0;
      cnt = 0;
      while (cnt < lim) begin
        ovf = 1'b0;
        mag2 = 128'(zr) * 128'(zr) + 128'(zi) * 128'(zi);
        if (mag2 >= (128'sd1 <<< (2 * FRAC + 2))) break;
        ar = zr;
        ai = zi;
        for (int k = 1; k < pw && !ovf; k++) begin
          nr = round_sum(128'(ar) * 128'(zr) - 128'(ai) * 128'(zi), ovf);
          ni = round_sum(128'(ar) * 128'(zi) + 128'(ai) * 128'(zr), ovf);
          ar = nr;
          ai = ni;
        end
        zr = clip_q4(128'(ar) + 128'(cr), ovf);
        zi = clip_q4(128'(ai) + 128'(ci), ovf);
        cnt++;
        if (ovf) break;
      end
      return cnt[ITER_CFG_W-1:0];
    endfunction

    function void note_request(bit [PIXEL_W-1:0] col, bit [PIXEL_W-1:0] row);
      count_q.push_back(escape_count(col, row));
    endfunction

    function void check_result(bit [ITER_CFG_W-1:0] got);
      bit [ITER_CFG_W-1:0] want;
      if (count_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: iteration_count=%0d", got);
        return;
      end
      want = count_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: iteration_count expected %0d, actual %0d", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [PIXEL_W-1:0] in_pixel_col;
  logic [PIXEL_W-1:0] in_pixel_row;
  logic out_valid;
  logic out_stall;
  logic [ITER_CFG_W-1:0] out_iteration_count;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  escape_count_board board = new();
  bit idle_on = 1'b1;
  longint cycles = 0;

  multibrot_escape_time_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pixel_col(in_pixel_col),
    .in_pixel_row(in_pixel_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_iteration_count(out_iteration_count),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check accepted counts, then stall at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) board.check_result(out_iteration_count);
      out_stall <= idle_on && ($urandom % 100 < 17);
    end
  end

  task automatic send_pixel(int unsigned col, int unsigned row);
    in_valid <= 1'b1;
    in_pixel_col <= col[PIXEL_W-1:0];
    in_pixel_row <= row[PIXEL_W-1:0];
    do @(posedge clk); while (in_stall);
    board.note_request(col[PIXEL_W-1:0], row[PIXEL_W-1:0]);
    if (idle_on && ($urandom % 100 < 17)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.write_reg(idx, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.count_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned p, int unsigned m);
    drain();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_POWER, p);
    write_reg(CFG_MAX_ITERATIONS, m);
  endtask

  // Mostly pixels inside the image, some anywhere in the field range.
  task automatic send_random_pixel();
    int unsigned wmax;
    int unsigned hmax;
    wmax = (board.width_reg == 0) ? 0 : (board.width_reg > 4096 ? 4095 : board.width_reg - 1);
    hmax = (board.height_reg == 0) ? 0 : (board.height_reg > 4096 ? 4095 : board.height_reg - 1);
    if ($urandom % 100 < 85) send_pixel($urandom_range(0, wmax), $urandom_range(0, hmax));
    else send_pixel($urandom % 4096, $urandom % 4096);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_col = '0;
    in_pixel_row = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: image center, corners and far outside pixels.
    send_pixel(320, 240);
    send_pixel(0, 0);
    send_pixel(639, 479);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(160, 240);

    // Zero dimensions and power, zero limit.
    configure(0, 0, 0, 0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(2730, 1365);

    // Oversized dimension, power and limit.
    configure(8191, 4096, 15, 2047);
    send_pixel(2048, 2048);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    send_pixel(1000, 2048);

    // Unit dimensions at power one: c is zero at the origin.
    configure(1, 1, 1, 1024);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 3);
    send_pixel(4095, 4095);

    configure(16, 16, 8, 1024);
    send_pixel(8, 8);
    send_pixel(15, 0);

    // Random settings, one phase without any idling.
    for (int ph = 0; ph < 6; ph++) begin
      configure($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 8),
                $urandom_range(0, 100));
      idle_on = (ph != 2);
      for (int i = 0; i < 20; i++) send_random_pixel();
    end

    drain();
    if (board.mismatches == 0 && board.count_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
sv/mbet_pkg.sv
sv/mbet_div_cell.sv
sv/multibrot_escape_time_unit.sv
tb/multibrot_escape_time_unit_tb.sv
